FILE: rtl/ckpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckpu_pkg: shared types and constants for the chroma key unmix core
// Pixel classes, the queued item layout and the register indexes.
// ----------------------------------------------------------------------------
package ckpu_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned D2_W    = 18;

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_KEY_RED     = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY_GREEN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY_BLUE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CLEAR_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_SOLID_LIMIT = 3'd4;

  // pixel class decided in the front end
  typedef enum logic [1:0] {
    CLS_KEYED,
    CLS_OPAQUE,
    CLS_RAMP
  } ckpu_cls_t;

  typedef struct packed {
    ckpu_cls_t         cls;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [D2_W-1:0]   d2;
  } ckpu_item_t;

  // handshake between queue and a neighbor
  typedef struct packed {
    logic valid;
    logic full;
  } ckpu_qstat_t;

endpackage

FILE: rtl/ckpu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckpu_front: pixel intake and classification
// Computes the squared key distance, registers it and sorts each pixel into
// keyed, opaque or ramp before pushing it into the queue.
// ----------------------------------------------------------------------------
module ckpu_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ckpu_pkg::CHAN_W-1:0]  red,
  input  logic [ckpu_pkg::CHAN_W-1:0]  green,
  input  logic [ckpu_pkg::CHAN_W-1:0]  blue,
  input  logic [ckpu_pkg::CHAN_W-1:0]  key_red,
  input  logic [ckpu_pkg::CHAN_W-1:0]  key_green,
  input  logic [ckpu_pkg::CHAN_W-1:0]  key_blue,
  input  logic [ckpu_pkg::LIMIT_W-1:0] clear_limit,
  input  logic [ckpu_pkg::LIMIT_W-1:0] solid_limit,
  input  ckpu_pkg::ckpu_qstat_t        qstat,
  output logic                         push,
  output ckpu_pkg::ckpu_item_t         push_item
);
  import ckpu_pkg::*;

  logic              f_vld;
  logic [CHAN_W-1:0] f_red, f_green, f_blue;
  logic [D2_W-1:0]   f_d2;
  logic [D2_W-1:0]   clear_sq, solid_sq;
  logic [D2_W-1:0]   d2_in;
  logic [CHAN_W-1:0] dr, dg, db;
  logic              front_en;

  function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // squared distance to the key color, full 16-bit squares
  always_comb begin
    dr = absdiff(red, key_red);
    dg = absdiff(green, key_green);
    db = absdiff(blue, key_blue);
    d2_in = {2'b00, {8'b0, dr} * {8'b0, dr}} + {2'b00, {8'b0, dg} * {8'b0, dg}}
            + {2'b00, {8'b0, db} * {8'b0, db}};
  end

  assign front_en = !f_vld || !qstat.full;
  assign in_stall = !front_en;
  assign push     = f_vld && !qstat.full;

  // hold squared limits in registers
  always_ff @(posedge clk) begin
    clear_sq <= D2_W'(clear_limit * clear_limit);
    solid_sq <= D2_W'(solid_limit * solid_limit);
  end

  // advance intake register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (front_en) begin
      f_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en && in_valid) begin
      f_red   <= red;
      f_green <= green;
      f_blue  <= blue;
      f_d2    <= d2_in;
    end
  end

  // classify against the limits
  always_comb begin
    push_item.red   = f_red;
    push_item.green = f_green;
    push_item.blue  = f_blue;
    push_item.d2    = f_d2;
    priority if (f_d2 <= clear_sq) begin
      push_item.cls = CLS_KEYED;
    end else if (f_d2 >= solid_sq) begin
      push_item.cls = CLS_OPAQUE;
    end else begin
      push_item.cls = CLS_RAMP;
    end
  end

endmodule

FILE: rtl/ckpu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckpu_queue: short item queue
// Decouples the classifying front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module ckpu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ckpu_pkg::ckpu_item_t  push_item,
  input  logic                  pop,
  output ckpu_pkg::ckpu_qstat_t qstat,
  output ckpu_pkg::ckpu_item_t  head_item
);
  import ckpu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ckpu_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_pop;

  assign qstat.valid = (cnt != '0);
  assign qstat.full  = (cnt == CNT_W'(DEPTH));
  assign do_pop      = pop && qstat.valid;
  assign head_item   = mem[rd_ptr];

  // store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!push && do_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ckpu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckpu_back: matte and unmix pipeline
// Bit-per-stage square root, alpha division and per-channel unmix division,
// then the output register. The whole pipe holds while the output stalls.
// ----------------------------------------------------------------------------
module ckpu_back (
  input  logic                         clk,
  input  logic                         rst,
  input  ckpu_pkg::ckpu_qstat_t        qstat,
  input  ckpu_pkg::ckpu_item_t         head_item,
  output logic                         pop,
  input  logic [ckpu_pkg::CHAN_W-1:0]  key_red,
  input  logic [ckpu_pkg::CHAN_W-1:0]  key_green,
  input  logic [ckpu_pkg::CHAN_W-1:0]  key_blue,
  input  logic [ckpu_pkg::LIMIT_W-1:0] clear_limit,
  input  logic [ckpu_pkg::LIMIT_W-1:0] solid_limit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ckpu_pkg::CHAN_W-1:0]  out_red,
  output logic [ckpu_pkg::CHAN_W-1:0]  out_green,
  output logic [ckpu_pkg::CHAN_W-1:0]  out_blue,
  output logic [ckpu_pkg::CHAN_W-1:0]  out_alpha,
  output logic                         keyed_out
);
  import ckpu_pkg::*;

  localparam int unsigned ROOT_W = 17;
  localparam int unsigned DV_N   = 16;
  localparam int unsigned UD_N   = 8;
  localparam int unsigned P_DV   = ROOT_W;
  localparam int unsigned P_MUL  = P_DV + DV_N;
  localparam int unsigned P_PREP = P_MUL + 1;
  localparam int unsigned P_UD   = P_PREP + 1;
  localparam int unsigned P_END  = P_UD + UD_N;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0]       over;
    logic [2:0][23:0] rem;
    logic [2:0][7:0]  q;
  } um_t;

  logic              en;
  logic              vld [P_END+1];
  ckpu_item_t        it  [P_END+1];
  logic [17:0]       sq_rem  [1:ROOT_W];
  logic [ROOT_W-1:0] sq_root [1:ROOT_W];
  logic [16:0]       dv_rem  [P_DV+1:P_MUL];
  logic [15:0]       dv_q    [P_DV+1:P_MUL];
  logic [15:0]       al      [P_PREP:P_END];
  logic [2:0][25:0]  num;
  um_t               um      [P_UD:P_END];
  logic [16:0]       span, dv_start;
  logic [2:0][7:0]   pix, key;
  logic [23:0]       aprod;

  assign en  = !(out_valid && out_stall);
  assign pop = en && qstat.valid;

  // advance the item chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= P_END; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= qstat.valid;
      for (int i = 0; i < P_END; i++) vld[i+1] <= vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[0] <= head_item;
      for (int i = 0; i < P_END; i++) it[i+1] <= it[i];
    end
  end

  // square root of d2 * 2^16, one result bit per stage
  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    logic [17:0]       cur_rem;
    logic [ROOT_W-1:0] cur_root;
    logic [33:0]       v;
    logic [19:0]       cat, trial, diff;
    logic              ge;
    if (g == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_root = '0;
    end else begin : g_next
      assign cur_rem  = sq_rem[g];
      assign cur_root = sq_root[g];
    end
    assign v     = {it[g].d2, 16'b0};
    assign cat   = {cur_rem, v[33-2*g -: 2]};
    assign trial = {1'b0, cur_root, 2'b01};
    assign ge    = (cat >= trial);
    assign diff  = cat - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[g+1]  <= ge ? diff[17:0] : cat[17:0];
        sq_root[g+1] <= {cur_root[ROOT_W-2:0], ge};
      end
    end
  end

  // alpha = (d - clear*256) * 2^16 / span, one quotient bit per stage
  assign span     = {solid_limit - clear_limit, 8'b0};
  assign dv_start = sq_root[ROOT_W] - {clear_limit, 8'b0};

  for (genvar g = 0; g < DV_N; g++) begin : g_div
    logic [16:0] cur_rem;
    logic [15:0] cur_q;
    logic [17:0] sh, diff;
    logic        ge;
    if (g == 0) begin : g_first
      assign cur_rem = dv_start;
      assign cur_q   = '0;
    end else begin : g_next
      assign cur_rem = dv_rem[P_DV+g];
      assign cur_q   = dv_q[P_DV+g];
    end
    assign sh   = {cur_rem, 1'b0};
    assign ge   = (sh >= {1'b0, span});
    assign diff = sh - {1'b0, span};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[P_DV+g+1] <= ge ? diff[16:0] : sh[16:0];
        dv_q[P_DV+g+1]   <= {cur_q[14:0], ge};
      end
    end
  end

  // unmix numerators: p * 2^16 - (2^16 - alpha) * k
  assign key = {key_blue, key_green, key_red};
  assign pix = {it[P_MUL].blue, it[P_MUL].green, it[P_MUL].red};

  always_ff @(posedge clk) begin
    if (en) begin
      al[P_PREP] <= dv_q[P_MUL];
      for (int c = 0; c < 3; c++) begin
        num[c] <= {2'b00, pix[c], 16'b0}
                  - {1'b0, 25'((17'h10000 - {1'b0, dv_q[P_MUL]}) * key[c])};
      end
    end
  end

  // sort numerators: non-positive, saturating, or divide
  always_ff @(posedge clk) begin
    if (en) begin
      al[P_UD] <= al[P_PREP];
      for (int c = 0; c < 3; c++) begin
        um[P_UD].neg[c]  <= num[c][25] || (num[c] == '0);
        um[P_UD].over[c] <= !num[c][25] && (num[c][24:0] >= {1'b0, al[P_PREP], 8'b0});
        um[P_UD].rem[c]  <= num[c][23:0];
        um[P_UD].q[c]    <= '0;
      end
    end
  end

  // quotient num / alpha, one bit per stage from the top
  for (genvar g = 0; g < UD_N; g++) begin : g_udiv
    logic [23:0] dvs;
    assign dvs = {8'b0, al[P_UD+g]} << (UD_N - 1 - g);
    always_ff @(posedge clk) begin
      if (en) begin
        al[P_UD+g+1]      <= al[P_UD+g];
        um[P_UD+g+1].neg  <= um[P_UD+g].neg;
        um[P_UD+g+1].over <= um[P_UD+g].over;
        for (int c = 0; c < 3; c++) begin
          if (um[P_UD+g].rem[c] >= dvs) begin
            um[P_UD+g+1].rem[c] <= um[P_UD+g].rem[c] - dvs;
            um[P_UD+g+1].q[c]   <= {um[P_UD+g].q[c][6:0], 1'b1};
          end else begin
            um[P_UD+g+1].rem[c] <= um[P_UD+g].rem[c];
            um[P_UD+g+1].q[c]   <= {um[P_UD+g].q[c][6:0], 1'b0};
          end
        end
      end
    end
  end

  // rounded 8-bit alpha
  assign aprod = {al[P_END], 8'b0} - {8'b0, al[P_END]} + 24'h008000;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[P_END];
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0][7:0] val;
    logic            keyed;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        val[c] = um[P_END].neg[c] ? 8'd0 : (um[P_END].over[c] ? 8'd255 : um[P_END].q[c]);
      end
      keyed = (it[P_END].cls == CLS_KEYED)
              || ((it[P_END].cls == CLS_RAMP) && (al[P_END] == '0));
      if (keyed) begin
        out_red   <= '0;
        out_green <= '0;
        out_blue  <= '0;
        out_alpha <= '0;
        keyed_out <= 1'b1;
      end else if (it[P_END].cls == CLS_OPAQUE) begin
        out_red   <= it[P_END].red;
        out_green <= it[P_END].green;
        out_blue  <= it[P_END].blue;
        out_alpha <= 8'd255;
        keyed_out <= 1'b0;
      end else begin
        out_red   <= val[0];
        out_green <= val[1];
        out_blue  <= val[2];
        out_alpha <= aprod[23:16];
        keyed_out <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/chroma_key_pixel_unmix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_key_pixel_unmix_core: chroma key matte with color unmixing
// Keys RGB pixels against a programmable key color and distance limits.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall with red, green, blue. A pixel
//   transfers on a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with out_red, out_green, out_blue,
//   out_alpha and keyed_out, one result per pixel, in order.
//   Configuration: cfg_we with cfg_index / cfg_data writes key_red,
//   key_green, key_blue, clear_limit, solid_limit (indexes 0 to 4); other
//   indexes are ignored. Write only while no pixel is in flight.
//   Throughput: one pixel per clock while the output is not stalled. The pipe
//   consists of the 17-stage square root, the 16-stage alpha divider and the
//   8-stage unmix divider, plus intake, queue and output registers.
//   Reset: clears all valid flags and the queue and restores the default
//   key (black) and limits (40 and 95).
//   Stall: while out_stall holds a valid result, the back pipe freezes; the
//   queue fills up to QUEUE_DEPTH pixels and the intake register takes one more
//   before in_stall rises.
// ----------------------------------------------------------------------------
module chroma_key_pixel_unmix_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ckpu_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ckpu_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ckpu_pkg::CHAN_W-1:0]  red,
  input  logic [ckpu_pkg::CHAN_W-1:0]  green,
  input  logic [ckpu_pkg::CHAN_W-1:0]  blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ckpu_pkg::CHAN_W-1:0]  out_red,
  output logic [ckpu_pkg::CHAN_W-1:0]  out_green,
  output logic [ckpu_pkg::CHAN_W-1:0]  out_blue,
  output logic [ckpu_pkg::CHAN_W-1:0]  out_alpha,
  output logic                         keyed_out
);
  import ckpu_pkg::*;

  logic [CHAN_W-1:0]  key_red, key_green, key_blue;
  logic [LIMIT_W-1:0] clear_limit, solid_limit;
  logic               push, pop;
  ckpu_item_t         push_item, head_item;
  ckpu_qstat_t        qstat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_red     <= '0;
      key_green   <= '0;
      key_blue    <= '0;
      clear_limit <= LIMIT_W'(40);
      solid_limit <= LIMIT_W'(95);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_RED:     key_red     <= cfg_data[CHAN_W-1:0];
        REG_KEY_GREEN:   key_green   <= cfg_data[CHAN_W-1:0];
        REG_KEY_BLUE:    key_blue    <= cfg_data[CHAN_W-1:0];
        REG_CLEAR_LIMIT: clear_limit <= cfg_data[LIMIT_W-1:0];
        REG_SOLID_LIMIT: solid_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  ckpu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .key_red     (key_red),
    .key_green   (key_green),
    .key_blue    (key_blue),
    .clear_limit (clear_limit),
    .solid_limit (solid_limit),
    .qstat       (qstat),
    .push        (push),
    .push_item   (push_item)
  );

  ckpu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .qstat     (qstat),
    .head_item (head_item)
  );

  ckpu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .head_item   (head_item),
    .pop         (pop),
    .key_red     (key_red),
    .key_green   (key_green),
    .key_blue    (key_blue),
    .clear_limit (clear_limit),
    .solid_limit (solid_limit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .keyed_out   (keyed_out)
  );

  // a keyed-out pixel is fully transparent and black
  a_keyed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && keyed_out |-> out_alpha == '0 && out_red == '0
                               && out_green == '0 && out_blue == '0)
    else $error("keyed pixel with nonzero fields");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // the intake only stalls once the queue has filled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> qstat.full)
    else $error("input stalled with room in the queue");

endmodule
